>>> rtl/hsmb_pkg.sv
// shared constants, types and codes for the stitching map builder
package hsmb_pkg;

    localparam int CAMERAS      = 4;
    localparam int CAM_BITS     = 3;
    localparam int WIDX_BITS    = 4;
    localparam int COORD_BITS   = 12;
    localparam int COEF_W       = 48;
    localparam int GEOM_W       = 12;
    localparam int ACC_W        = 64;
    localparam int QBITS        = 8;
    localparam int DIST_W       = 24;
    localparam int MAP_COLS     = 256;
    localparam int MAP_ROWS     = 256;
    localparam int MAP_COL_BITS = 8;
    localparam int MAP_ROW_BITS = 8;
    localparam int MAP_ADDR_W   = MAP_COL_BITS + MAP_ROW_BITS;
    localparam int TAB_ADDR_W   = CAM_BITS + WIDX_BITS;
    localparam int SIZE_W       = 9;

    localparam logic [1:0] REG_MAP_WIDTH  = 2'd0;
    localparam logic [1:0] REG_MAP_HEIGHT = 2'd1;

    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_PIXEL = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    localparam logic [WIDX_BITS-1:0] WIDX_DEN_LAST = 4'd8;
    localparam logic [WIDX_BITS-1:0] WIDX_WIDTH    = 4'd9;
    localparam logic [WIDX_BITS-1:0] WIDX_HEIGHT   = 4'd10;
    localparam logic [WIDX_BITS-1:0] WIDX_LEFT     = 4'd11;
    localparam logic [WIDX_BITS-1:0] WIDX_TOP      = 4'd12;
    localparam logic [WIDX_BITS-1:0] WIDX_RIGHT    = 4'd13;
    localparam logic [WIDX_BITS-1:0] WIDX_BOTTOM   = 4'd14;

    typedef struct packed {
        logic                  valid;
        logic [DIST_W-1:0]     sq_dist;
        logic [CAM_BITS-1:0]   cam;
        logic [COORD_BITS-1:0] row;
        logic [COORD_BITS-1:0] col;
    } map_entry_t;

    typedef struct packed {
        logic             done;
        logic             fits;
        logic [QBITS-1:0] q;
    } div_res_t;

endpackage

>>> rtl/hsmb_ram.sv
// generic simple dual-port ram with registered read data
module hsmb_ram #(
    parameter int DATA_W = 8,
    parameter int ADDR_W = 4
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/hsmb_div.sv
// truncating divider that yields a quotient in 0..255 or flags it out of range
module hsmb_div import hsmb_pkg::*; (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [ACC_W-1:0] num,
    input  logic signed [ACC_W-1:0] den,
    output div_res_t                res
);

    localparam int SH_W = ACC_W + QBITS;

    logic             busy_reg;
    logic             check_reg;
    logic [3:0]       cnt_reg;
    logic             done_reg;
    logic             fits_reg;
    logic             neg_reg;
    logic [ACC_W-1:0] rem_reg;
    logic [ACC_W-1:0] ad_reg;
    logic [SH_W-1:0]  dsh_reg;
    logic [QBITS-1:0] q_reg;
    logic [SH_W-1:0]  rem_ext;
    logic             ge;

    assign rem_ext = SH_W'(rem_reg);
    assign ge      = rem_ext >= dsh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            check_reg <= 1'b0;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                check_reg <= 1'b1;
                cnt_reg   <= 4'(QBITS);
            end
            else if (busy_reg && check_reg)
            begin
                check_reg <= 1'b0;
                if (neg_reg || rem_ext >= {ad_reg, {QBITS{1'b0}}})
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 4'd1;
                if (cnt_reg == 4'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num[ACC_W-1] ? ACC_W'(-num) : num;
            ad_reg  <= den[ACC_W-1] ? ACC_W'(-den) : den;
            neg_reg <= num[ACC_W-1] ^ den[ACC_W-1];
            q_reg   <= '0;
        end
        else if (busy_reg && check_reg)
        begin
            dsh_reg <= SH_W'(ad_reg) << (QBITS - 1);
            if (neg_reg)
            begin
                fits_reg <= rem_reg < ad_reg;
            end
            else
            begin
                fits_reg <= rem_ext < {ad_reg, {QBITS{1'b0}}};
            end
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                rem_reg <= ACC_W'(rem_ext - dsh_reg);
            end
            q_reg   <= {q_reg[QBITS-2:0], ge};
            dsh_reg <= dsh_reg >> 1;
        end
    end

    assign res.done = done_reg;
    assign res.fits = fits_reg;
    assign res.q    = q_reg;

endmodule

>>> rtl/homography_stitch_map_builder.sv
// top level: camera table, projection sequencer and source map
// a pixel reads 15 table words one per cycle from the table ram, then two
// divisions and a read-modify-write of the map ram; rejects end earlier
// throughput: one item at a time, the next word is taken once the result is registered
// reset: all 65536 map ram entries cleared with in_ready low, map sizes back to 256
module homography_stitch_map_builder import hsmb_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [1:0]               cfg_index,
    input  logic [SIZE_W-1:0]        cfg_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [1:0]               mode,
    input  logic [CAM_BITS-1:0]      camera,
    input  logic [WIDX_BITS-1:0]     word_index,
    input  logic signed [COEF_W-1:0] word_value,
    input  logic [COORD_BITS-1:0]    src_col,
    input  logic [COORD_BITS-1:0]    src_row,
    input  logic [MAP_COL_BITS-1:0]  dst_col,
    input  logic [MAP_ROW_BITS-1:0]  dst_row,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     rejected,
    output logic                     updated,
    output logic [MAP_COL_BITS-1:0]  target_col,
    output logic [MAP_ROW_BITS-1:0]  target_row,
    output logic                     entry_valid,
    output logic [DIST_W-1:0]        entry_dist,
    output logic [CAM_BITS-1:0]      entry_camera,
    output logic [COORD_BITS-1:0]    entry_src_row,
    output logic [COORD_BITS-1:0]    entry_src_col
);

    localparam logic [3:0] ST_CLEAR  = 4'd0;
    localparam logic [3:0] ST_IDLE   = 4'd1;
    localparam logic [3:0] ST_TREAD  = 4'd2;
    localparam logic [3:0] ST_CHECK  = 4'd3;
    localparam logic [3:0] ST_DIVX   = 4'd4;
    localparam logic [3:0] ST_DIVY   = 4'd5;
    localparam logic [3:0] ST_MAPRD  = 4'd6;
    localparam logic [3:0] ST_MAPWR  = 4'd7;
    localparam logic [3:0] ST_RDWAIT = 4'd8;
    localparam logic [3:0] ST_DONE   = 4'd9;

    localparam int ENTRY_W = $bits(map_entry_t);

    logic [3:0]              state_reg, state_next;
    logic [MAP_ADDR_W-1:0]   clr_reg;
    logic [SIZE_W-1:0]       map_width_reg, map_height_reg;
    logic                    in_acc;

    logic [CAM_BITS-1:0]     cam_reg;
    logic [COORD_BITS-1:0]   c_reg, r_reg;
    logic [WIDX_BITS-1:0]    rd_cnt_reg;
    logic                    rdv_reg, pv_reg;
    logic [WIDX_BITS-1:0]    rdi_reg, pi_reg;
    logic signed [COEF_W+COORD_BITS:0] prod_reg;
    logic signed [ACC_W-1:0] nx_reg, ny_reg, dn_reg;
    logic [GEOM_W-1:0]       geom_w_reg, geom_h_reg, geom_l_reg;
    logic [GEOM_W-1:0]       geom_t_reg, geom_r_reg, geom_b_reg;
    logic [DIST_W-1:0]       sqx_reg, sqy_reg, dist_reg;
    logic [MAP_COL_BITS-1:0] tc_reg;
    logic [MAP_ROW_BITS-1:0] tr_reg;
    logic                    hit_reg;

    logic                    p_rejected_reg, p_updated_reg;
    logic [MAP_COL_BITS-1:0] p_tc_reg;
    logic [MAP_ROW_BITS-1:0] p_tr_reg;
    map_entry_t              p_entry_reg;

    logic                    out_valid_reg;
    logic                    rejected_reg, updated_reg;
    logic [MAP_COL_BITS-1:0] target_col_reg;
    logic [MAP_ROW_BITS-1:0] target_row_reg;
    map_entry_t              entry_reg;

    logic                    tab_we, tab_re;
    logic [TAB_ADDR_W-1:0]   tab_waddr, tab_raddr;
    logic [COEF_W-1:0]       tab_wdata, tab_rdata;
    logic signed [COORD_BITS:0] mul_sel;

    logic                    map_we, map_re;
    logic [MAP_ADDR_W-1:0]   map_waddr, map_raddr;
    map_entry_t              map_wdata, map_rdata;
    logic [ENTRY_W-1:0]      map_rdata_raw;

    logic                    div_start;
    logic signed [ACC_W-1:0] div_num;
    div_res_t                div_res;

    logic [SIZE_W-1:0]       cols, rows;
    logic                    border_bad;
    logic signed [COORD_BITS:0] dx, dy;
    logic [2*COORD_BITS+1:0] sqx_full, sqy_full;
    logic [DIST_W:0]         dsum;
    logic                    col_ok, row_ok, replace, rd_in_map;
    logic                    out_load;

    assign cfg_ready = 1'b1;
    assign in_ready  = state_reg == ST_IDLE;
    assign in_acc    = in_valid && in_ready;
    assign out_load  = state_reg == ST_DONE && (!out_valid_reg || out_ready);

    // camera table ram
    assign tab_we    = in_acc && mode == MODE_LOAD && 32'(camera) < CAMERAS
                       && word_index <= WIDX_BOTTOM;
    assign tab_waddr = {camera, word_index};
    assign tab_wdata = (word_index <= WIDX_DEN_LAST) ? word_value
                                                    : COEF_W'(word_value[GEOM_W-1:0]);
    assign tab_re    = state_reg == ST_TREAD && rd_cnt_reg <= WIDX_BOTTOM;
    assign tab_raddr = {cam_reg, rd_cnt_reg};

    hsmb_ram #(.DATA_W(COEF_W), .ADDR_W(TAB_ADDR_W)) u_tab (
        .clk   (clk),
        .we    (tab_we),
        .waddr (tab_waddr),
        .wdata (tab_wdata),
        .re    (tab_re),
        .raddr (tab_raddr),
        .rdata (tab_rdata)
    );

    // source map ram
    assign rd_in_map = 32'(dst_col) < MAP_COLS && 32'(dst_row) < MAP_ROWS;
    assign map_re    = (state_reg == ST_MAPRD)
                       || (in_acc && mode == MODE_READ && rd_in_map);
    assign map_raddr = (state_reg == ST_MAPRD) ? {tr_reg, tc_reg} : {dst_row, dst_col};
    assign map_rdata = map_entry_t'(map_rdata_raw);
    assign replace   = !map_rdata.valid || dist_reg < map_rdata.sq_dist;
    assign map_we    = (state_reg == ST_CLEAR) || (state_reg == ST_MAPWR && replace);
    assign map_waddr = (state_reg == ST_CLEAR) ? clr_reg : {tr_reg, tc_reg};

    always_comb
    begin
        map_wdata       = '0;
        if (state_reg == ST_MAPWR)
        begin
            map_wdata.valid   = 1'b1;
            map_wdata.sq_dist = dist_reg;
            map_wdata.cam     = cam_reg;
            map_wdata.row     = r_reg;
            map_wdata.col     = c_reg;
        end
    end

    hsmb_ram #(.DATA_W(ENTRY_W), .ADDR_W(MAP_ADDR_W)) u_map (
        .clk   (clk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .re    (map_re),
        .raddr (map_raddr),
        .rdata (map_rdata_raw)
    );

    // divider
    assign div_start = (state_reg == ST_CHECK && !border_bad)
                       || (state_reg == ST_DIVX && div_res.done && col_ok);
    assign div_num   = (state_reg == ST_CHECK) ? nx_reg : ny_reg;

    hsmb_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (dn_reg),
        .res   (div_res)
    );

    assign cols   = (map_width_reg > SIZE_W'(MAP_COLS)) ? SIZE_W'(MAP_COLS) : map_width_reg;
    assign rows   = (map_height_reg > SIZE_W'(MAP_ROWS)) ? SIZE_W'(MAP_ROWS) : map_height_reg;
    assign col_ok = div_res.fits && SIZE_W'(div_res.q) < cols;
    assign row_ok = div_res.fits && SIZE_W'(div_res.q) < rows;

    assign border_bad = c_reg < geom_l_reg
                        || ({1'b0, c_reg} + {1'b0, geom_r_reg}) >= {1'b0, geom_w_reg}
                        || r_reg < geom_t_reg
                        || ({1'b0, r_reg} + {1'b0, geom_b_reg}) >= {1'b0, geom_h_reg}
                        || dn_reg == '0;

    assign dx       = $signed({1'b0, c_reg}) - $signed({2'b0, geom_w_reg[GEOM_W-1:1]});
    assign dy       = $signed({1'b0, r_reg}) - $signed({2'b0, geom_h_reg[GEOM_W-1:1]});
    assign sqx_full = 26'(dx * dx);
    assign sqy_full = 26'(dy * dy);
    assign dsum     = {1'b0, sqx_reg} + {1'b0, sqy_reg};

    always_comb
    begin
        case (rdi_reg)
            4'd0, 4'd3, 4'd6: mul_sel = $signed({1'b0, c_reg});
            4'd1, 4'd4, 4'd7: mul_sel = $signed({1'b0, r_reg});
            default:          mul_sel = 13'sd1;
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (mode == MODE_PIXEL && 32'(camera) < CAMERAS)
                    begin
                        state_next = ST_TREAD;
                    end
                    else if (mode == MODE_READ)
                    begin
                        state_next = ST_RDWAIT;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_TREAD:
            begin
                if (rdv_reg && rdi_reg == WIDX_BOTTOM)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = border_bad ? ST_DONE : ST_DIVX;
            end
            ST_DIVX:
            begin
                if (div_res.done)
                begin
                    state_next = col_ok ? ST_DIVY : ST_DONE;
                end
            end
            ST_DIVY:
            begin
                if (div_res.done)
                begin
                    state_next = row_ok ? ST_MAPRD : ST_DONE;
                end
            end
            ST_MAPRD:  state_next = ST_MAPWR;
            ST_MAPWR:  state_next = ST_DONE;
            ST_RDWAIT: state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_reg        <= '0;
            map_width_reg  <= SIZE_W'(256);
            map_height_reg <= SIZE_W'(256);
            out_valid_reg  <= 1'b0;
            rdv_reg        <= 1'b0;
            pv_reg         <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_reg <= clr_reg + MAP_ADDR_W'(1);
            end
            if (cfg_valid && cfg_index == REG_MAP_WIDTH)
            begin
                map_width_reg <= cfg_data;
            end
            if (cfg_valid && cfg_index == REG_MAP_HEIGHT)
            begin
                map_height_reg <= cfg_data;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            rdv_reg <= tab_re;
            pv_reg  <= rdv_reg && rdi_reg <= WIDX_DEN_LAST;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        rdi_reg  <= rd_cnt_reg;
        pi_reg   <= rdi_reg;
        prod_reg <= $signed(tab_rdata) * mul_sel;
        if (tab_re)
        begin
            rd_cnt_reg <= rd_cnt_reg + 4'd1;
        end
        if (rdv_reg)
        begin
            case (rdi_reg)
                WIDX_WIDTH:  geom_w_reg <= tab_rdata[GEOM_W-1:0];
                WIDX_HEIGHT: geom_h_reg <= tab_rdata[GEOM_W-1:0];
                WIDX_LEFT:   geom_l_reg <= tab_rdata[GEOM_W-1:0];
                WIDX_TOP:    geom_t_reg <= tab_rdata[GEOM_W-1:0];
                WIDX_RIGHT:  geom_r_reg <= tab_rdata[GEOM_W-1:0];
                WIDX_BOTTOM: geom_b_reg <= tab_rdata[GEOM_W-1:0];
                default:     ;
            endcase
        end
        if (pv_reg)
        begin
            case (pi_reg)
                4'd0, 4'd1, 4'd2: nx_reg <= nx_reg + ACC_W'(prod_reg);
                4'd3, 4'd4, 4'd5: ny_reg <= ny_reg + ACC_W'(prod_reg);
                default:          dn_reg <= dn_reg + ACC_W'(prod_reg);
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    cam_reg        <= camera;
                    c_reg          <= src_col;
                    r_reg          <= src_row;
                    rd_cnt_reg     <= '0;
                    nx_reg         <= '0;
                    ny_reg         <= '0;
                    dn_reg         <= '0;
                    hit_reg        <= rd_in_map;
                    p_rejected_reg <= mode == MODE_PIXEL;
                    p_updated_reg  <= 1'b0;
                    p_tc_reg       <= '0;
                    p_tr_reg       <= '0;
                    p_entry_reg    <= '0;
                end
            end
            ST_CHECK:
            begin
                sqx_reg <= sqx_full[DIST_W-1:0];
                sqy_reg <= sqy_full[DIST_W-1:0];
            end
            ST_DIVX:
            begin
                tc_reg <= div_res.q;
            end
            ST_DIVY:
            begin
                tr_reg <= div_res.q;
            end
            ST_MAPRD:
            begin
                dist_reg <= dsum[DIST_W] ? '1 : dsum[DIST_W-1:0];
            end
            ST_MAPWR:
            begin
                p_rejected_reg <= 1'b0;
                p_updated_reg  <= replace;
                p_tc_reg       <= tc_reg;
                p_tr_reg       <= tr_reg;
            end
            ST_RDWAIT:
            begin
                if (hit_reg && map_rdata.valid)
                begin
                    p_entry_reg <= map_rdata;
                end
            end
            default: ;
        endcase

        if (out_load)
        begin
            rejected_reg   <= p_rejected_reg;
            updated_reg    <= p_updated_reg;
            target_col_reg <= p_tc_reg;
            target_row_reg <= p_tr_reg;
            entry_reg      <= p_entry_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign rejected      = rejected_reg;
    assign updated       = updated_reg;
    assign target_col    = target_col_reg;
    assign target_row    = target_row_reg;
    assign entry_valid   = entry_reg.valid;
    assign entry_dist    = entry_reg.sq_dist;
    assign entry_camera  = entry_reg.cam;
    assign entry_src_row = entry_reg.row;
    assign entry_src_col = entry_reg.col;

endmodule

>>> rtl/hsmb_checker.sv
// port-level checker for the stitching map builder and its bind
module hsmb_checker import hsmb_pkg::*; (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_ready,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic                    rejected,
    input logic                    updated,
    input logic [MAP_COL_BITS-1:0] target_col,
    input logic [MAP_ROW_BITS-1:0] target_row,
    input logic                    entry_valid,
    input logic [DIST_W-1:0]       entry_dist
);

    // a held word stays valid
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output word dropped while stalled");

    // one item in flight at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while an item is in work");

    a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && rejected |-> !updated && target_col == '0 && target_row == '0)
        else $error("rejected pixel carries a target");

    a_update_no_entry: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (updated || rejected) |-> !entry_valid && entry_dist == '0)
        else $error("pixel result carries map entry fields");

endmodule

bind homography_stitch_map_builder hsmb_checker u_hsmb_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .rejected   (rejected),
    .updated    (updated),
    .target_col (target_col),
    .target_row (target_row),
    .entry_valid(entry_valid),
    .entry_dist (entry_dist)
);
